/* rtl/brlm_pkg.sv */
// Package for the block RMS level meter: register indexes, limits,
// job and result words, and the back-end state type. No dependencies.
package brlm_pkg;

    localparam int MAX_BLOCK_LEN = 4096;
    localparam int MAX_GROUPS    = 8;
    localparam int BPG_MAX       = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int LEN_W   = 13;
    localparam int BPG_W   = 5;
    localparam int GPF_W   = 4;
    localparam int CNT_W   = 12;
    localparam int SQ_W    = 31;
    localparam int BSUM_W  = 43;
    localparam int GSUM_W  = 47;
    localparam int GDIV_W  = 17;
    localparam int BIG_W   = 4;
    localparam int GC_W    = 3;
    localparam int BIDX_W  = 7;
    localparam int RMS_W   = 16;
    localparam int QUO_W   = 48;
    localparam int ROOT_W  = 24;

    localparam int JQ_DEPTH = 2;
    localparam int JQ_PTR_W = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
    localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_LEN        = 2'd0,
        CFG_BLOCKS_PER_GROUP = 2'd1,
        CFG_GROUPS_PER_FRAME = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0] block_len;
        logic [BPG_W-1:0] blocks_per_group;
        logic [GPF_W-1:0] groups_per_frame;
    } t_cfg;

    typedef struct packed {
        logic [BSUM_W-1:0] bsum;
        logic [GSUM_W-1:0] gsum;
        logic [LEN_W-1:0]  len;
        logic [GDIV_W-1:0] gdiv;
        logic [BIDX_W-1:0] block_index;
        logic [GC_W-1:0]   group_index;
        logic              group_valid;
        logic              frame_last;
    } t_job;

    typedef struct packed {
        logic [RMS_W-1:0]  block_rms;
        logic [BIDX_W-1:0] block_index;
        logic              group_valid;
        logic [RMS_W-1:0]  group_rms;
        logic [GC_W-1:0]   group_index;
        logic              frame_last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_HOLD
    } t_back_state;

endpackage

/* rtl/brlm_front.sv */
// Front end: squares each sample, keeps block and group sums and counters,
// and emits a job word at the end of every block. Uses brlm_pkg.
module brlm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  brlm_pkg::t_cfg  i_cfg,
    input  logic            i_push,
    output logic            o_full,
    input  logic [15:0]     i_sample,
    output logic            o_job_push,
    output brlm_pkg::t_job  o_job,
    input  logic            i_job_full
);
    import brlm_pkg::*;

    logic              r_sq_v;
    logic [SQ_W-1:0]   r_sq;
    logic [CNT_W-1:0]  r_cnt;
    logic [BSUM_W-1:0] r_bsum;
    logic [GSUM_W-1:0] r_gsum;
    logic [BIG_W-1:0]  r_big;
    logic [GC_W-1:0]   r_gc;
    logic [BIDX_W-1:0] r_fbc;

    logic              accept;
    logic [16:0]       ext;
    logic [16:0]       mag;
    logic [33:0]       sq_full;
    logic [LEN_W-1:0]  len;
    logic [BPG_W-1:0]  bpg;
    logic [GPF_W-1:0]  gpf;
    logic [BSUM_W-1:0] sum_b;
    logic [GSUM_W-1:0] sum_g;
    logic [CNT_W:0]    cnt_inc;
    logic [BIG_W:0]    big_inc;
    logic [GC_W:0]     gc_inc;
    logic              bdone;
    logic              gdone;
    logic              last;
    logic [17:0]       gdiv_full;

    assign o_full = r_sq_v | i_job_full;
    assign accept = i_push & ~o_full;

    assign ext     = {i_sample[15], i_sample};
    assign mag     = i_sample[15] ? (~ext + 17'd1) : ext;
    assign sq_full = mag * mag;

    // limits saturated to their legal ranges
    always_comb begin
        priority if (i_cfg.block_len == '0)
            len = LEN_W'(1);
        else if (i_cfg.block_len > LEN_W'(MAX_BLOCK_LEN))
            len = LEN_W'(MAX_BLOCK_LEN);
        else
            len = i_cfg.block_len;
        priority if (i_cfg.blocks_per_group == '0)
            bpg = BPG_W'(1);
        else if (i_cfg.blocks_per_group > BPG_W'(BPG_MAX))
            bpg = BPG_W'(BPG_MAX);
        else
            bpg = i_cfg.blocks_per_group;
        priority if (i_cfg.groups_per_frame == '0)
            gpf = GPF_W'(1);
        else if (i_cfg.groups_per_frame > GPF_W'(MAX_GROUPS))
            gpf = GPF_W'(MAX_GROUPS);
        else
            gpf = i_cfg.groups_per_frame;
    end

    assign sum_b     = r_bsum + BSUM_W'(r_sq);
    assign sum_g     = r_gsum + GSUM_W'(r_sq);
    assign cnt_inc   = {1'b0, r_cnt} + 1'b1;
    assign big_inc   = {1'b0, r_big} + 1'b1;
    assign gc_inc    = {1'b0, r_gc} + 1'b1;
    assign bdone     = cnt_inc >= (CNT_W+1)'(len);
    assign gdone     = big_inc >= (BIG_W+1)'(bpg);
    assign last      = gdone & (gc_inc >= (GC_W+1)'(gpf));
    assign gdiv_full = len * bpg;

    assign o_job_push        = r_sq_v & bdone;
    assign o_job.bsum        = sum_b;
    assign o_job.gsum        = sum_g;
    assign o_job.len         = len;
    assign o_job.gdiv        = gdiv_full[GDIV_W-1:0];
    assign o_job.block_index = r_fbc;
    assign o_job.group_index = r_gc;
    assign o_job.group_valid = gdone;
    assign o_job.frame_last  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
            r_cnt  <= '0;
            r_bsum <= '0;
            r_gsum <= '0;
            r_big  <= '0;
            r_gc   <= '0;
            r_fbc  <= '0;
        end else begin
            r_sq_v <= accept;
            if (r_sq_v) begin
                if (bdone) begin
                    r_cnt  <= '0;
                    r_bsum <= '0;
                    if (gdone) begin
                        r_gsum <= '0;
                        r_big  <= '0;
                        if (last) begin
                            r_gc  <= '0;
                            r_fbc <= '0;
                        end else begin
                            r_gc  <= gc_inc[GC_W-1:0];
                            r_fbc <= r_fbc + 1'b1;
                        end
                    end else begin
                        r_gsum <= sum_g;
                        r_big  <= big_inc[BIG_W-1:0];
                        r_fbc  <= r_fbc + 1'b1;
                    end
                end else begin
                    r_cnt  <= cnt_inc[CNT_W-1:0];
                    r_bsum <= sum_b;
                    r_gsum <= sum_g;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_sq <= sq_full[SQ_W-1:0];
    end

endmodule

/* rtl/brlm_job_queue.sv */
// Short queue of job words between front and back end.
// Uses brlm_pkg for the job type and depth.
module brlm_job_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  brlm_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output brlm_pkg::t_job  o_job
);
    import brlm_pkg::*;

    t_job                r_mem [JQ_DEPTH];
    logic [JQ_PTR_W-1:0] r_wr;
    logic [JQ_PTR_W-1:0] r_rd;
    logic [JQ_CNT_W-1:0] r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_cnt == JQ_CNT_W'(JQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)
                r_rd <= (r_rd == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push & ~do_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (do_pop & ~do_push)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

endmodule

/* rtl/brlm_back.sv */
// Back end: one shared bit-serial divider and one two-bit-a-step square
// root, used for the block value and, when a group ends, the group value; holds the result word.
// Uses brlm_pkg.
module brlm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_empty,
    input  brlm_pkg::t_job  i_job,
    output logic            o_job_pop,
    output brlm_pkg::t_res  o_res,
    output logic            o_res_valid,
    input  logic            i_res_pop
);
    import brlm_pkg::*;

    localparam int DVS_W  = GDIV_W;
    localparam int STEP_W = $clog2(GSUM_W);
    localparam int SREM_W = ROOT_W + 2;

    t_back_state       r_state;
    t_back_state       n_state;
    t_job              r_job;
    logic              r_phase;
    logic [STEP_W-1:0] r_step;
    logic [GSUM_W-1:0] r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [QUO_W-1:0]  r_sv;
    logic [SREM_W-1:0] r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [RMS_W-1:0]  r_brms;
    t_res              r_res;
    logic              r_res_v;

    logic [DVS_W:0]    d_sh;
    logic              d_bit;
    logic [DVS_W-1:0]  d_rem;
    logic [GSUM_W-1:0] d_quo;
    logic [SREM_W+1:0] s_sh;
    logic [SREM_W+1:0] s_trial;
    logic              s_bit;
    logic [SREM_W-1:0] s_rem;
    logic [ROOT_W-1:0] s_root;
    logic              slot_free;

    // divider step
    assign d_sh  = {r_rem, r_quo[GSUM_W-1]};
    assign d_bit = d_sh >= {1'b0, r_dvs};
    assign d_rem = d_bit ? DVS_W'(d_sh - {1'b0, r_dvs}) : d_sh[DVS_W-1:0];
    assign d_quo = {r_quo[GSUM_W-2:0], d_bit};

    // square root step; the full root is kept, the ports take its low bits
    assign s_sh    = {r_srem, r_sv[QUO_W-1 -: 2]};
    assign s_trial = {2'b00, r_root, 2'b01};
    assign s_bit   = s_sh >= s_trial;
    assign s_rem   = s_bit ? SREM_W'(s_sh - s_trial) : s_sh[SREM_W-1:0];
    assign s_root  = {r_root[ROOT_W-2:0], s_bit};

    assign slot_free   = ~r_res_v | i_res_pop;
    assign o_res       = r_res;
    assign o_res_valid = r_res_v;

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == '0) n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_step == '0)
                    n_state = (!r_phase && r_job.group_valid) ? ST_DIV : ST_HOLD;
            end
            ST_HOLD: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_res_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_HOLD && slot_free)
                r_res_v <= 1'b1;
            else if (i_res_pop)
                r_res_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_job   <= i_job;
                r_phase <= 1'b0;
                r_quo   <= GSUM_W'(i_job.bsum);
                r_dvs   <= DVS_W'(i_job.len);
                r_rem   <= '0;
                r_step  <= STEP_W'(GSUM_W - 1);
            end
            ST_DIV: begin
                r_quo <= d_quo;
                r_rem <= d_rem;
                if (r_step == '0) begin
                    r_sv   <= QUO_W'(d_quo);
                    r_srem <= '0;
                    r_root <= '0;
                    r_step <= STEP_W'(ROOT_W - 1);
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            ST_SQRT: begin
                r_sv   <= {r_sv[QUO_W-3:0], 2'b00};
                r_srem <= s_rem;
                r_root <= s_root;
                if (r_step == '0) begin
                    if (!r_phase) begin
                        r_brms  <= s_root[RMS_W-1:0];
                        r_phase <= 1'b1;
                        r_quo   <= r_job.gsum;
                        r_dvs   <= r_job.gdiv;
                        r_rem   <= '0;
                        r_step  <= STEP_W'(GSUM_W - 1);
                    end
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    r_res.block_rms   <= r_brms;
                    r_res.block_index <= r_job.block_index;
                    r_res.group_valid <= r_job.group_valid;
                    r_res.group_rms   <= r_job.group_valid ? r_root[RMS_W-1:0] : '0;
                    r_res.group_index <= r_job.group_index;
                    r_res.frame_last  <= r_job.frame_last;
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/block_rms_level_meter.sv */
// Block RMS level meter, top level: configuration registers, front end,
// job queue and back end. Uses brlm_pkg, brlm_front, brlm_job_queue, brlm_back.
// A sample word is squared into a register and then accumulated; no new word is taken while
// a square is pending or the two-entry job queue is full. The back end runs a 47-step divide
// and a 24-step root for the block value, and again for the group value when a block ends a
// group. Synchronous active-low reset clears sums, counters and queues; registers go to 200/10/8.
module block_rms_level_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [15:0]                         i_sample,
    output logic                                empty,
    input  logic                                pop,
    output logic [brlm_pkg::RMS_W-1:0]          o_block_rms,
    output logic [brlm_pkg::BIDX_W-1:0]         o_block_index,
    output logic                                o_group_valid,
    output logic [brlm_pkg::RMS_W-1:0]          o_group_rms,
    output logic [brlm_pkg::GC_W-1:0]           o_group_index,
    output logic                                o_frame_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [brlm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [brlm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import brlm_pkg::*;

    t_cfg r_cfg;
    logic job_push;
    t_job job_in;
    logic job_full;
    logic job_pop;
    logic job_empty;
    t_job job_out;
    t_res res;
    logic res_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_len        <= LEN_W'(200);
            r_cfg.blocks_per_group <= BPG_W'(10);
            r_cfg.groups_per_frame <= GPF_W'(8);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BLOCK_LEN:        r_cfg.block_len        <= i_cfg_data[LEN_W-1:0];
                CFG_BLOCKS_PER_GROUP: r_cfg.blocks_per_group <= i_cfg_data[BPG_W-1:0];
                CFG_GROUPS_PER_FRAME: r_cfg.groups_per_frame <= i_cfg_data[GPF_W-1:0];
                default: ;
            endcase
        end
    end

    brlm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_sample   (i_sample),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    brlm_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_job   (job_out)
    );

    brlm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_pop   (pop)
    );

    assign empty         = ~res_valid;
    assign o_block_rms   = res.block_rms;
    assign o_block_index = res.block_index;
    assign o_group_valid = res.group_valid;
    assign o_group_rms   = res.group_rms;
    assign o_group_index = res.group_index;
    assign o_frame_last  = res.frame_last;

endmodule

/* tb/sv/tb.sv */
// Testbench for block_rms_level_meter: drives samples and register writes, predicts
// each block/group RMS reading and checks every popped word against it.
// Depends on brlm_pkg and the RTL of block_rms_level_meter.
module tb;
    import brlm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int QUIET_CYCLES = 300;
    localparam int STALL_LIMIT  = 20000;

    class rms_reading_board;
        t_res        due_readings[$];
        int unsigned cfg_len, cfg_bpg, cfg_gpf;
        int unsigned n_in_block, blk_in_grp, grp_no, blk_no;
        longint unsigned blk_sq, grp_sq;
        int unsigned bad_readings;

        function new();
            cfg_len = 200;
            cfg_bpg = 10;
            cfg_gpf = 8;
            n_in_block = 0;
            blk_in_grp = 0;
            grp_no = 0;
            blk_no = 0;
            blk_sq = 0;
            grp_sq = 0;
            bad_readings = 0;
        endfunction

        function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // low bits of the floor root, as the ports carry it
        function logic [RMS_W-1:0] floor_root(longint unsigned v);
            longint unsigned r, t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r[RMS_W-1:0];
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BLOCK_LEN:        cfg_len = data;
                CFG_BLOCKS_PER_GROUP: cfg_bpg = data[BPG_W-1:0];
                CFG_GROUPS_PER_FRAME: cfg_gpf = data[GPF_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic [15:0] s);
            int unsigned len, bpg, gpf, mag;
            longint unsigned sq;
            bit grp_done;
            t_res r;
            len = clip(cfg_len, 1, MAX_BLOCK_LEN);
            bpg = clip(cfg_bpg, 1, BPG_MAX);
            gpf = clip(cfg_gpf, 1, MAX_GROUPS);
            mag = s[15] ? 32'h10000 - s : s;
            sq = mag;
            sq = sq * sq;
            blk_sq += sq;
            grp_sq += sq;
            n_in_block++;
            if (n_in_block < len) return;

            r = '0;
            r.block_rms   = floor_root(blk_sq / len);
            r.block_index = blk_no[BIDX_W-1:0];
            r.group_index = grp_no[GC_W-1:0];
            blk_in_grp++;
            grp_done = blk_in_grp >= bpg;
            r.group_valid = grp_done;
            r.frame_last  = grp_done && (grp_no + 1 >= gpf);
            if (grp_done) begin
                sq = len;
                r.group_rms = floor_root(grp_sq / (sq * bpg));
            end
            due_readings.push_back(r);

            n_in_block = 0;
            blk_sq = 0;
            blk_no = (blk_no + 1) % 128;
            if (grp_done) begin
                grp_sq = 0;
                blk_in_grp = 0;
                if (r.frame_last) begin
                    grp_no = 0;
                    blk_no = 0;
                end else begin
                    grp_no++;
                end
            end
        endfunction

        function void check_reading(t_res got);
            t_res want;
            if (due_readings.size() == 0) begin
                bad_readings++;
                if (bad_readings <= 10)
                    $display("reading with none due: rms %0d idx %0d", got.block_rms,
                             got.block_index);
                return;
            end
            want = due_readings.pop_front();
            if (got.block_rms !== want.block_rms || got.block_index !== want.block_index ||
                got.group_valid !== want.group_valid || got.group_rms !== want.group_rms ||
                got.group_index !== want.group_index || got.frame_last !== want.frame_last)
            begin
                bad_readings++;
                if (bad_readings <= 10) begin
                    $display("want rms %0d idx %0d gv %0d grms %0d gidx %0d last %0d",
                             want.block_rms, want.block_index, want.group_valid,
                             want.group_rms, want.group_index, want.frame_last);
                    $display("got  rms %0d idx %0d gv %0d grms %0d gidx %0d last %0d",
                             got.block_rms, got.block_index, got.group_valid,
                             got.group_rms, got.group_index, got.frame_last);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [15:0]           i_sample;
    logic                  empty;
    logic                  pop;
    logic [RMS_W-1:0]      o_block_rms;
    logic [BIDX_W-1:0]     o_block_index;
    logic                  o_group_valid;
    logic [RMS_W-1:0]      o_group_rms;
    logic [GC_W-1:0]       o_group_index;
    logic                  o_frame_last;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rms_reading_board board;
    bit               tx_jitter;
    bit               rx_jitter;
    bit               moved;
    int unsigned      stall_cycles = 0;
    t_res             seen;

    block_rms_level_meter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample      (i_sample),
        .empty         (empty),
        .pop           (pop),
        .o_block_rms   (o_block_rms),
        .o_block_index (o_block_index),
        .o_group_valid (o_group_valid),
        .o_group_rms   (o_group_rms),
        .o_group_index (o_group_index),
        .o_frame_last  (o_frame_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                board.apply_reg(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (push && !full) begin
                board.take_sample(i_sample);
                moved = 1'b1;
            end
            if (pop && !empty) begin
                seen.block_rms   = o_block_rms;
                seen.block_index = o_block_index;
                seen.group_valid = o_group_valid;
                seen.group_rms   = o_group_rms;
                seen.group_index = o_group_index;
                seen.frame_last  = o_frame_last;
                board.check_reading(seen);
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result side: pop is stalled at random, in bursts
    initial begin
        int unsigned hold;
        hold = 0;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold != 0) begin
                pop <= 1'b0;
                hold--;
            end else if (rx_jitter && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                hold = $urandom_range(0, 12);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [15:0] s);
        if (tx_jitter && $urandom_range(0, 6) == 0) begin
            push <= 1'b0;
            i_sample <= 16'($urandom);
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop pushing, wait for every due reading, then let the back end go quiet
    task automatic settle();
        push <= 1'b0;
        while (board.due_readings.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pad_high(int unsigned v, int unsigned w);
        logic [CFG_DATA_W-1:0] r;
        r = CFG_DATA_W'($urandom);
        r = (r << w) | CFG_DATA_W'(v);
        return r;
    endfunction

    function automatic logic [15:0] random_sample();
        logic [9:0] low_bits;
        low_bits = 10'($urandom);
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return {{6{low_bits[9]}}, low_bits};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int unsigned len, input int unsigned bpg,
                             input int unsigned gpf, input int unsigned n);
        write_reg(CFG_BLOCK_LEN, CFG_DATA_W'(len));
        write_reg(CFG_BLOCKS_PER_GROUP, pad_high(bpg, BPG_W));
        write_reg(CFG_GROUPS_PER_FRAME, pad_high(gpf, GPF_W));
        repeat (n) send_sample(random_sample());
        settle();
    endtask

    initial begin
        logic [15:0] corner_vals[7];
        int unsigned len, bpg, gpf;
        corner_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
        board = new();
        i_rst_n = 1'b0;
        push = 1'b0;
        i_sample = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero in every register saturates to one: each word ends block, group and frame
        write_reg(CFG_BLOCK_LEN, '0);
        write_reg(CFG_BLOCKS_PER_GROUP, '0);
        write_reg(CFG_GROUPS_PER_FRAME, '0);
        foreach (corner_vals[k]) send_sample(corner_vals[k]);
        settle();

        // over-range group settings, then a shorter block written mid-block
        write_reg(CFG_BLOCK_LEN, 13'd3);
        write_reg(CFG_BLOCKS_PER_GROUP, pad_high(31, BPG_W));
        write_reg(CFG_GROUPS_PER_FRAME, pad_high(15, GPF_W));
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8001);
        send_sample(16'h7FFE);
        send_sample(16'h1234);
        settle();
        write_reg(CFG_BLOCK_LEN, 13'd2);
        write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h0100);
        settle();

        // over-range length saturates; a long full-scale block then ends early
        write_reg(CFG_BLOCK_LEN, 13'h1FFF);
        write_reg(CFG_BLOCKS_PER_GROUP, 13'd16);
        write_reg(CFG_GROUPS_PER_FRAME, 13'd8);
        repeat (400) send_sample(16'h8000);
        settle();
        write_reg(CFG_BLOCK_LEN, 13'd401);
        send_sample(16'h8000);
        settle();

        // one-sample blocks close that heavy group (root wider than the port),
        // then run a full frame so the block index wraps
        run_phase(1, 16, 8, 140);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph >= 4) begin
                tx_jitter = 1'b0;
                rx_jitter = 1'b0;
            end else begin
                tx_jitter = $urandom_range(0, 3) != 0;
                rx_jitter = $urandom_range(0, 3) != 0;
            end
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(9, 40);
                default: len = $urandom_range(1, 8);
            endcase
            bpg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
            gpf = $urandom_range(0, 15);
            run_phase(len, bpg, gpf, $urandom_range(90, 130));
        end

        if (board.bad_readings == 0 && board.due_readings.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
